// ===== rtl/fpc_pkg.sv =====
// package for the fixed point cosine unit: pipeline depth and polynomial constants
// no dependencies; used by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package fpc_pkg;

  // pipeline depth from input word to output register
  localparam int unsigned NUM_STG = 5;

  localparam logic [15:0] ONE_Q15    = 16'd32768;
  localparam logic [15:0] COEF_A_Q16 = 16'd15310;
  localparam logic [15:0] COEF_B_HI  = 16'd10;
  localparam logic [31:0] RND_BIAS   = 32'h0000_8000;

  typedef logic [NUM_STG-1:0] stg_vec_t;

endpackage

`default_nettype wire

// ===== rtl/fpc_mul_rnd.sv =====
// unsigned 16x16 multiply keeping the high half, rounded to nearest, ties up
// depends on fpc_pkg for the rounding bias
`timescale 1ns / 1ps
`default_nettype none

module fpc_mul_rnd (
  input  wire logic [15:0] a,
  input  wire logic [15:0] b,
  output logic      [15:0] p
);

  logic [31:0] prod;

  always_comb begin
    prod = 32'(a) * 32'(b) + fpc_pkg::RND_BIAS;
    p    = prod[31:16];
  end

endmodule

`default_nettype wire

// ===== rtl/fpc_datapath.sv =====
// five register stages of the cosine evaluation: fold, square, coefficients,
// inner product, outer product with sign; depends on fpc_pkg and fpc_mul_rnd
`timescale 1ns / 1ps
`default_nettype none

module fpc_datapath (
  input  wire logic             clk,
  input  wire fpc_pkg::stg_vec_t ld,
  input  wire logic [15:0]      angle,
  output logic      [15:0]      cosine
);

  logic [15:0] t_r, t_nxt;
  logic        neg1_r, neg1_nxt;
  logic [15:0] u2_r, u2_nxt;
  logic        neg2_r;
  logic [15:0] u3_r, omu3_r, omu3_nxt, poly3_r, poly3_nxt;
  logic        neg3_r;
  logic [15:0] inner4_r, inner4_nxt, omu4_r;
  logic        neg4_r;
  logic [15:0] cos_r, cos_nxt;

  logic [15:0] frac;
  logic [15:0] sq;
  logic [15:0] up;
  logic [15:0] mag;
  logic [15:0] slope;

  fpc_mul_rnd u_mul_sq (.a(t_r),    .b(t_r),      .p(sq));
  fpc_mul_rnd u_mul_up (.a(u3_r),   .b(poly3_r),  .p(up));
  fpc_mul_rnd u_mul_mg (.a(omu4_r), .b(inner4_r), .p(mag));

  always_comb begin
    // fold the low 14 bits into a .15 fraction, mirrored in odd quadrants
    frac     = {1'b0, angle[13:0], 1'b0};
    t_nxt    = angle[14] ? (fpc_pkg::ONE_Q15 - frac) : frac;
    neg1_nxt = angle[15] ^ angle[14];

    // square is at most 2^14, so the doubled value fits 16 bits
    u2_nxt = {sq[14:0], 1'b0};

    slope     = 16'(u2_r[15:8]) * fpc_pkg::COEF_B_HI;
    poly3_nxt = fpc_pkg::COEF_A_Q16 - slope;
    omu3_nxt  = fpc_pkg::ONE_Q15 - u2_r;

    inner4_nxt = fpc_pkg::ONE_Q15 - up;

    cos_nxt = neg4_r ? (16'd0 - mag) : mag;
    cosine  = cos_r;
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      t_r    <= t_nxt;
      neg1_r <= neg1_nxt;
    end
    if (ld[1]) begin
      u2_r   <= u2_nxt;
      neg2_r <= neg1_r;
    end
    if (ld[2]) begin
      u3_r    <= u2_r;
      omu3_r  <= omu3_nxt;
      poly3_r <= poly3_nxt;
      neg3_r  <= neg2_r;
    end
    if (ld[3]) begin
      inner4_r <= inner4_nxt;
      omu4_r   <= omu3_r;
      neg4_r   <= neg3_r;
    end
    if (ld[4]) begin
      cos_r <= cos_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/fixed_point_cosine_unit.sv =====
// fixed point cosine unit: takes a 16-bit angle word and returns a Q2.14 cosine word
// angle units are 2*pi/65536; the two top bits pick the quadrant
// input channel: in_valid / in_ready carry in_angle
// output channel: out_valid / out_ready carry out_cosine, signed, -16384..16384
// a word moves on a rising edge where valid and ready are both high
// the datapath is a five stage pipeline: fold, square, coefficients,
// inner product, outer product with sign into the output register
// out_valid rises once the accepted word reaches the output register, and the word
// leaves on an edge with out_ready high; one word per cycle while out_ready is high
// each stage holds its word while the stage after it is full and stalled, and
// loads whenever it is empty or its word moves on, so bubbles close up
// in_ready is low only when all five stages hold words and out_ready is low
// reset clears the stage valid bits; the pipeline comes up empty
// depends on fpc_pkg and fpc_datapath
`timescale 1ns / 1ps
`default_nettype none

module fixed_point_cosine_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [15:0] in_angle,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic signed [15:0] out_cosine
);

  fpc_pkg::stg_vec_t vld_r, vld_nxt;
  fpc_pkg::stg_vec_t ld;
  fpc_pkg::stg_vec_t vin;
  logic [15:0]       cos_w;

  always_comb begin
    // a stage can load when it is empty or the next stage takes its word
    ld[fpc_pkg::NUM_STG-1] = ~vld_r[fpc_pkg::NUM_STG-1] | out_ready;
    for (int k = fpc_pkg::NUM_STG - 2; k >= 0; k--) begin
      ld[k] = ~vld_r[k] | ld[k+1];
    end
    vin = {vld_r[fpc_pkg::NUM_STG-2:0], in_valid};
    for (int k = 0; k < fpc_pkg::NUM_STG; k++) begin
      vld_nxt[k] = ld[k] ? vin[k] : vld_r[k];
    end
    in_ready   = ld[0];
    out_valid  = vld_r[fpc_pkg::NUM_STG-1];
    out_cosine = signed'(cos_w);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  fpc_datapath u_datapath (
    .clk    (clk),
    .ld     (ld),
    .angle  (in_angle),
    .cosine (cos_w)
  );

endmodule

`default_nettype wire
